// File: hw/rtl/bcte_pkg.sv
package bcte_pkg;

    localparam int REG_W       = 7;
    localparam int VAL_W       = 8;
    localparam int FUNC_W      = 3;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = FUNC_W;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 1;

    // Hours register layout.
    localparam int FMT_POS = 6;
    localparam int PM_POS  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET_TIME      = 3'd0,
        FUNC_INC_HOUR      = 3'd1,
        FUNC_DEC_HOUR      = 3'd2,
        FUNC_INC_MIN       = 3'd3,
        FUNC_DEC_MIN       = 3'd4,
        FUNC_SET_FORMAT    = 3'd5,
        FUNC_TOGGLE_FORMAT = 3'd6,
        FUNC_INVALID       = 3'd7
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [VAL_W-1:0]   hour_value;
        logic [VAL_W-1:0]   minute_value;
        logic [VAL_W-1:0]   second_value;
        logic               pm_flag;
        logic               want_12_hour;
    } t_cmd;

    typedef struct packed {
        logic [REG_W-1:0]   hours;
        logic [REG_W-1:0]   minutes;
        logic [REG_W-1:0]   seconds;
    } t_regs;

endpackage

// File: hw/rtl/bcte_edit.sv
module bcte_edit (
    input  bcte_pkg::t_cmd  i_cmd,
    input  bcte_pkg::t_regs i_regs,
    output bcte_pkg::t_regs o_regs,
    output logic            o_accepted
);
    import bcte_pkg::*;

    // Binary to packed BCD for values below 64; tens = floor(v * 13 / 128).
    function automatic logic [6:0] to_bcd(input logic [5:0] v);
        logic [9:0] prod;
        logic [2:0] tens;
        logic [6:0] tens_x10;
        logic [3:0] ones;
        begin
            prod     = 10'(v) * 10'd13;
            tens     = prod[9:7];
            tens_x10 = 7'(tens) * 7'd10;
            ones     = 4'(7'(v) - tens_x10);
            to_bcd   = {tens, ones};
        end
    endfunction

    function automatic logic [6:0] conv_12_to_24(input logic [6:0] h);
        logic [3:0] ones;
        logic [1:0] tens;
        begin
            ones = h[3:0];
            tens = {1'b0, h[4]};
            if (h[PM_POS]) begin
                if (tens == 2'd0) begin
                    if (ones < 4'd8) begin
                        ones = ones + 4'd2;
                        tens = 2'd1;
                    end else begin
                        ones = ones - 4'd8;
                        tens = 2'd2;
                    end
                end else if (ones < 4'd2) begin
                    ones = ones + 4'd2;
                    tens = 2'd2;
                end
            end else if (ones == 4'd2 && tens == 2'd1) begin
                ones = 4'd0;
                tens = 2'd0;
            end
            conv_12_to_24 = {1'b0, tens, ones};
        end
    endfunction

    function automatic logic [6:0] conv_24_to_12(input logic [6:0] h);
        logic [3:0] ones;
        logic [1:0] tens;
        logic       pm;
        begin
            ones = h[3:0];
            tens = h[5:4];
            pm   = 1'b0;
            if (tens == 2'd1) begin
                if (ones > 4'd2) begin
                    pm   = 1'b1;
                    ones = ones - 4'd2;
                    tens = 2'd0;
                end else if (ones == 4'd2) begin
                    pm = 1'b1;
                end
            end else if (tens == 2'd2) begin
                pm = 1'b1;
                if (ones >= 4'd2) begin
                    ones = ones - 4'd2;
                    tens = 2'd1;
                end else begin
                    ones = ones + 4'd8;
                    tens = 2'd0;
                end
            end else if (ones == 4'd0) begin
                ones = 4'd2;
                tens = 2'd1;
            end
            conv_24_to_12 = {1'b1, pm, tens[0], ones};
        end
    endfunction

    function automatic logic [6:0] hour_step(input logic [6:0] h, input logic up);
        logic [3:0] ones;
        logic [1:0] tens;
        logic       pm;
        begin
            ones = h[3:0];
            pm   = h[PM_POS];
            if (h[FMT_POS]) begin
                tens = {1'b0, h[4]};
                if (up) begin
                    if (tens[0]) begin
                        if (ones == 4'd2) begin
                            ones = 4'd1;
                            tens = 2'd0;
                        end else begin
                            ones = ones + 4'd1;
                            if (ones == 4'd2) begin
                                pm = ~pm;
                            end
                        end
                    end else if (ones >= 4'd9) begin
                        ones = 4'd0;
                        tens = 2'd1;
                    end else begin
                        ones = ones + 4'd1;
                    end
                end else begin
                    if (tens[0]) begin
                        if (ones == 4'd0) begin
                            ones = 4'd9;
                            tens = 2'd0;
                        end else begin
                            ones = ones - 4'd1;
                            if (ones == 4'd1) begin
                                pm = ~pm;
                            end
                        end
                    end else if (ones == 4'd1) begin
                        ones = 4'd2;
                        tens = 2'd1;
                    end else begin
                        ones = ones - 4'd1;
                    end
                end
                hour_step = {1'b1, pm, tens[0], ones};
            end else begin
                tens = h[5:4];
                if (up) begin
                    if (tens == 2'd2) begin
                        if (ones >= 4'd3) begin
                            ones = 4'd0;
                            tens = 2'd0;
                        end else begin
                            ones = ones + 4'd1;
                        end
                    end else if (ones >= 4'd9) begin
                        ones = 4'd0;
                        tens = tens + 2'd1;
                    end else begin
                        ones = ones + 4'd1;
                    end
                end else begin
                    if (tens != 2'd0) begin
                        if (ones == 4'd0) begin
                            ones = 4'd9;
                            tens = tens - 2'd1;
                        end else begin
                            ones = ones - 4'd1;
                        end
                    end else if (ones == 4'd0) begin
                        ones = 4'd3;
                        tens = 2'd2;
                    end else begin
                        ones = ones - 4'd1;
                    end
                end
                hour_step = {1'b0, tens, ones};
            end
        end
    endfunction

    function automatic logic [6:0] minute_step(input logic [6:0] m, input logic up);
        logic [3:0] ones;
        logic [2:0] tens;
        begin
            ones = m[3:0];
            tens = m[6:4];
            if (up) begin
                if (tens == 3'd5) begin
                    if (ones == 4'd9) begin
                        ones = 4'd0;
                        tens = 3'd0;
                    end else begin
                        ones = ones + 4'd1;
                    end
                end else if (ones == 4'd9) begin
                    ones = 4'd0;
                    tens = tens + 3'd1;
                end else begin
                    ones = ones + 4'd1;
                end
            end else if (ones == 4'd0) begin
                ones = 4'd9;
                tens = (tens == 3'd0) ? 3'd5 : tens - 3'd1;
            end else begin
                ones = ones - 4'd1;
            end
            minute_step = {tens, ones};
        end
    endfunction

    logic       w_is12;
    logic       w_min_ok;
    logic       w_sec_ok;
    logic       w_hour12_ok;
    logic       w_hour24_ok;
    logic [5:0] w_hour12_bin;
    logic [5:0] w_hour24_bin;
    logic [6:0] w_hour12_bcd;
    logic [6:0] w_hour24_bcd;
    logic [6:0] w_set_hours;
    logic [6:0] w_conv_hours;

    assign w_is12      = i_regs.hours[FMT_POS];
    assign w_min_ok    = i_cmd.minute_value < VAL_W'(60);
    assign w_sec_ok    = i_cmd.second_value < VAL_W'(60);
    assign w_hour12_ok = i_cmd.hour_value <= VAL_W'(12);
    assign w_hour24_ok = i_cmd.hour_value < VAL_W'(24);

    // In 12-hour form hour zero is stored as twelve.
    assign w_hour12_bin = (i_cmd.hour_value == '0) ? 6'd12 : i_cmd.hour_value[5:0];
    // In 24-hour form the PM flag only moves morning hours into the afternoon.
    assign w_hour24_bin = (i_cmd.pm_flag && i_cmd.hour_value < VAL_W'(12))
                        ? i_cmd.hour_value[5:0] + 6'd12 : i_cmd.hour_value[5:0];

    assign w_hour12_bcd = to_bcd(w_hour12_bin);
    assign w_hour24_bcd = to_bcd(w_hour24_bin);

    assign w_set_hours  = w_is12
                        ? {1'b1, i_cmd.pm_flag, w_hour12_bcd[4:0]}
                        : {1'b0, w_hour24_bcd[5:0]};
    assign w_conv_hours = w_is12 ? conv_12_to_24(i_regs.hours)
                                 : conv_24_to_12(i_regs.hours);

    always_comb begin
        o_regs     = i_regs;
        o_accepted = 1'b1;
        case (i_cmd.func)
            FUNC_SET_TIME: begin
                if (w_min_ok && w_sec_ok && (w_is12 ? w_hour12_ok : w_hour24_ok)) begin
                    o_regs.hours   = w_set_hours;
                    o_regs.minutes = to_bcd(i_cmd.minute_value[5:0]);
                    o_regs.seconds = to_bcd(i_cmd.second_value[5:0]);
                end else begin
                    o_accepted = 1'b0;
                end
            end
            FUNC_INC_HOUR: o_regs.hours = hour_step(i_regs.hours, 1'b1);
            FUNC_DEC_HOUR: o_regs.hours = hour_step(i_regs.hours, 1'b0);
            FUNC_INC_MIN:  o_regs.minutes = minute_step(i_regs.minutes, 1'b1);
            FUNC_DEC_MIN:  o_regs.minutes = minute_step(i_regs.minutes, 1'b0);
            FUNC_SET_FORMAT: begin
                if (w_is12 != i_cmd.want_12_hour) begin
                    o_regs.hours = w_conv_hours;
                end
            end
            FUNC_TOGGLE_FORMAT: o_regs.hours = w_conv_hours;
            default: o_accepted = 1'b0;
        endcase
    end

endmodule

// File: hw/rtl/bcd_clock_time_register_editor.sv
// A command beat passes the command register, then the result register, to the output.
// Throughput: one command per cycle while the output is not stalled; the edit is a
// single combinational pass between the command register and the result register.
// Reset (synchronous, active low) clears both stages and the time registers,
// which then read midnight in 24-hour form.
module bcd_clock_time_register_editor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // hour_value[7:0], minute_value[15:8], second_value[23:16], pm_flag[24],
    // want_12_hour[25], zero fill above
    input  logic [bcte_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // func[2:0]
    input  logic [bcte_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // seconds_bcd[6:0], minutes_bcd[13:7], hours_bcd[20:14], zero fill above
    output logic [bcte_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // accepted[0]
    output logic [bcte_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
    import bcte_pkg::*;

    localparam int OutPadW = OUT_TDATA_W - 3 * REG_W;

    logic   r_in_valid;
    t_cmd   r_cmd;
    t_regs  r_regs;
    logic   r_out_valid;
    t_regs  r_out_regs;
    logic   r_out_accepted;

    t_regs  n_regs;
    logic   n_accepted;
    logic   w_in_beat;
    logic   w_advance;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_beat     = s_axis_tvalid && s_axis_tready;

    bcte_edit u_edit (
        .i_cmd      (r_cmd),
        .i_regs     (r_regs),
        .o_regs     (n_regs),
        .o_accepted (n_accepted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs      <= '0;
        end else begin
            if (w_in_beat) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_regs      <= n_regs;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_cmd.func         <= t_func'(s_axis_tuser[FUNC_W-1:0]);
            r_cmd.hour_value   <= s_axis_tdata[7:0];
            r_cmd.minute_value <= s_axis_tdata[15:8];
            r_cmd.second_value <= s_axis_tdata[23:16];
            r_cmd.pm_flag      <= s_axis_tdata[24];
            r_cmd.want_12_hour <= s_axis_tdata[25];
        end
        if (w_advance) begin
            r_out_regs     <= n_regs;
            r_out_accepted <= n_accepted;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {OutPadW'(0), r_out_regs.hours, r_out_regs.minutes,
                            r_out_regs.seconds};
    assign m_axis_tuser  = OUT_TUSER_W'(r_out_accepted);

    // The result on the output always mirrors the live time registers.
    a_out_mirrors_regs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_regs == r_regs))
        else $error("output beat differs from time registers");

    // A rejected command leaves every time register untouched.
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !n_accepted) |=> $stable(r_regs))
        else $error("rejected command changed the time registers");

    // The invalid code is never reported as accepted.
    a_invalid_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_cmd.func == FUNC_INVALID) |=> (m_axis_tuser == '0))
        else $error("invalid command reported as accepted");

    // Minute stepping never touches the hours or seconds.
    a_minute_step_local: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_cmd.func == FUNC_INC_MIN || r_cmd.func == FUNC_DEC_MIN))
        |=> ($stable(r_regs.hours) && $stable(r_regs.seconds)))
        else $error("minute step changed hours or seconds");

endmodule
